FILE: hdl/alignment_site_classifier_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the alignment site classifier checker.
// ---------------------------------------------------------------------------
`ifndef ALIGNMENT_SITE_CLASSIFIER_TOP_MACROS_SVH
`define ALIGNMENT_SITE_CLASSIFIER_TOP_MACROS_SVH

// same-cycle implication, masked during reset
`define ASC_ASSERT_IMP(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define ASC_ASSERT_NXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);

// next-cycle implication, live through reset
`define ASC_ASSERT_RST(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ant) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/asc_pkg.sv
// ---------------------------------------------------------------------------
// asc_pkg
// Shared types, constants and helpers of the alignment site classifier.
// ---------------------------------------------------------------------------
package asc_pkg;

    localparam int ALPHABET_SIZE = 64;
    localparam int SYM_W         = 6;
    localparam int HIST_AW       = $clog2(ALPHABET_SIZE);
    localparam int TOTAL_W       = 24;
    localparam int N_TOTALS      = 6;

    // per-letter and per-column counts only need thresholds 1 and 2
    localparam int               CNT_W   = 2;
    localparam logic [CNT_W-1:0] CNT_ONE = 2'd1;
    localparam logic [CNT_W-1:0] CNT_SAT = 2'd2;

    localparam int RBUF_DEPTH = 3;
    localparam int RBUF_AW    = $clog2(RBUF_DEPTH);
    localparam int RBUF_CW    = $clog2(RBUF_DEPTH + 1);

    localparam int TDATA_IN_W  = 8;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 152;

    // running total slots
    localparam int TOT_COLUMNS   = 0;
    localparam int TOT_DIFF      = 1;
    localparam int TOT_INF       = 2;
    localparam int TOT_DIFF_GAPS = 3;
    localparam int TOT_INF_GAPS  = 4;
    localparam int TOT_GAPPED    = 5;

    typedef enum logic [1:0] {
        KIND_LETTER  = 2'd0,
        KIND_FEATURE = 2'd1,
        KIND_GAP     = 2'd2,
        KIND_OTHER   = 2'd3
    } t_kind;

    // what one histogram beat contributes to the column tallies
    typedef struct packed {
        logic valid;
        logic last;
        logic feature;
        logic gap;
        logic new_distinct;
        logic new_repeat;
    } t_evt;

    // declared high to low so the packed vector has is_different at bit 0
    typedef struct packed {
        logic [TOTAL_W-1:0] total_gapped;
        logic [TOTAL_W-1:0] total_informative_gaps;
        logic [TOTAL_W-1:0] total_different_gaps;
        logic [TOTAL_W-1:0] total_informative;
        logic [TOTAL_W-1:0] total_different;
        logic [TOTAL_W-1:0] total_columns;
        logic               no_letters;
        logic               informative_with_gaps;
        logic               different_with_gaps;
        logic               has_gap;
        logic               informative_site;
        logic               is_different;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_SAT) ? v : v + 1'b1;
    endfunction

endpackage

FILE: hdl/asc_ram.sv
// ---------------------------------------------------------------------------
// asc_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module asc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read-first: a same-address write is not seen by this read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: hdl/asc_hist.sv
// ---------------------------------------------------------------------------
// asc_hist
// Letter histogram: RAM read on accept, read-modify-write in the cycle after.
// ---------------------------------------------------------------------------
module asc_hist
    import asc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_acc,
    input  logic [SYM_W-1:0] i_symbol,
    input  t_kind            i_kind,
    input  logic             i_last,
    output t_evt             o_evt
);

    logic               r_s1_valid;
    logic [SYM_W-1:0]   r_s1_sym;
    t_kind              r_s1_kind;
    logic               r_s1_last;

    logic               r_fwd_valid, n_fwd_valid;
    logic [HIST_AW-1:0] r_fwd_addr;
    logic [CNT_W-1:0]   r_fwd_cnt;

    // entry holds a count for the current column
    logic [ALPHABET_SIZE-1:0] r_hit_valid, n_hit_valid;

    logic [HIST_AW-1:0] w_rd_addr;
    logic [HIST_AW-1:0] w_addr;
    logic [CNT_W-1:0]   w_rd_data;
    logic [CNT_W-1:0]   w_old;
    logic [CNT_W-1:0]   w_new;
    logic               w_letter;
    logic               w_hit;

    assign w_rd_addr = i_symbol[HIST_AW-1:0];
    assign w_addr    = r_s1_sym[HIST_AW-1:0];
    assign w_letter  = r_s1_valid && (r_s1_kind == KIND_LETTER)
                       && ({1'b0, r_s1_sym} < (SYM_W+1)'(ALPHABET_SIZE));

    asc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_letter),
        .i_waddr (w_addr),
        .i_wdata (w_new),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    // previous beat's write is not yet in the read data: forward it
    always_comb begin
        w_hit = r_fwd_valid && (r_fwd_addr == w_addr);
        if (!w_letter) begin
            w_old = '0;
        end else if (w_hit) begin
            w_old = r_fwd_cnt;
        end else if (r_hit_valid[w_addr]) begin
            w_old = w_rd_data;
        end else begin
            w_old = '0;
        end
        w_new = sat_inc(w_old);
    end

    always_comb begin
        n_hit_valid = r_hit_valid;
        n_fwd_valid = w_letter && !r_s1_last;
        if (r_s1_valid && r_s1_last) begin
            n_hit_valid = '0;
        end else if (w_letter) begin
            n_hit_valid[w_addr] = 1'b1;
        end
    end

    always_comb begin
        o_evt.valid        = r_s1_valid;
        o_evt.last         = r_s1_last;
        o_evt.feature      = w_letter || (r_s1_valid && (r_s1_kind == KIND_FEATURE));
        o_evt.gap          = r_s1_valid && (r_s1_kind == KIND_GAP);
        o_evt.new_distinct = w_letter && (w_old == '0);
        o_evt.new_repeat   = w_letter && (w_old == CNT_ONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_hit_valid <= '0;
        end else begin
            r_s1_valid  <= i_acc;
            r_fwd_valid <= n_fwd_valid;
            r_hit_valid <= n_hit_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_sym   <= i_symbol;
        r_s1_kind  <= i_kind;
        r_s1_last  <= i_last;
        r_fwd_addr <= w_addr;
        r_fwd_cnt  <= w_new;
    end

endmodule

FILE: hdl/asc_classify.sv
// ---------------------------------------------------------------------------
// asc_classify
// Column tallies, end-of-column flags and saturating running totals.
// ---------------------------------------------------------------------------
module asc_classify
    import asc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_evt    i_evt,
    output logic    o_push,
    output t_result o_result
);

    logic [CNT_W-1:0]   r_feat, r_gap, r_dist, r_rep;
    logic [CNT_W-1:0]   w_feat, w_gap, w_dist, w_rep;
    logic [TOTAL_W-1:0] r_tot [N_TOTALS];
    logic [TOTAL_W-1:0] n_tot [N_TOTALS];
    logic [N_TOTALS-1:0] w_bump;
    logic w_diff, w_inf, w_has_gap, w_diff2, w_inf2, w_none;

    always_comb begin
        w_feat = i_evt.feature      ? sat_inc(r_feat) : r_feat;
        w_gap  = i_evt.gap          ? sat_inc(r_gap)  : r_gap;
        w_dist = i_evt.new_distinct ? sat_inc(r_dist) : r_dist;
        w_rep  = i_evt.new_repeat   ? sat_inc(r_rep)  : r_rep;

        w_diff    = (w_dist == CNT_SAT);
        w_inf     = (w_rep == CNT_SAT);
        w_has_gap = (w_gap != '0);
        w_diff2   = w_diff || w_has_gap;
        w_inf2    = w_inf || ((w_gap == CNT_SAT) && (w_feat == CNT_SAT));
        w_none    = (w_dist == '0);

        w_bump[TOT_COLUMNS]   = 1'b1;
        w_bump[TOT_DIFF]      = w_diff;
        w_bump[TOT_INF]       = w_inf;
        w_bump[TOT_DIFF_GAPS] = w_diff2;
        w_bump[TOT_INF_GAPS]  = w_inf2;
        w_bump[TOT_GAPPED]    = w_has_gap;

        for (int i = 0; i < N_TOTALS; i++) begin
            n_tot[i] = (w_bump[i] && (r_tot[i] != '1)) ? r_tot[i] + 1'b1 : r_tot[i];
        end
    end

    assign o_push = i_evt.valid && i_evt.last;

    always_comb begin
        o_result.is_different           = w_diff;
        o_result.informative_site       = w_inf;
        o_result.has_gap                = w_has_gap;
        o_result.different_with_gaps    = w_diff2;
        o_result.informative_with_gaps  = w_inf2;
        o_result.no_letters             = w_none;
        o_result.total_columns          = n_tot[TOT_COLUMNS];
        o_result.total_different        = n_tot[TOT_DIFF];
        o_result.total_informative      = n_tot[TOT_INF];
        o_result.total_different_gaps   = n_tot[TOT_DIFF_GAPS];
        o_result.total_informative_gaps = n_tot[TOT_INF_GAPS];
        o_result.total_gapped           = n_tot[TOT_GAPPED];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feat <= '0;
            r_gap  <= '0;
            r_dist <= '0;
            r_rep  <= '0;
            for (int i = 0; i < N_TOTALS; i++) begin
                r_tot[i] <= '0;
            end
        end else if (i_evt.valid) begin
            if (i_evt.last) begin
                r_feat <= '0;
                r_gap  <= '0;
                r_dist <= '0;
                r_rep  <= '0;
                for (int i = 0; i < N_TOTALS; i++) begin
                    r_tot[i] <= n_tot[i];
                end
            end else begin
                r_feat <= w_feat;
                r_gap  <= w_gap;
                r_dist <= w_dist;
                r_rep  <= w_rep;
            end
        end
    end

endmodule

FILE: hdl/asc_rbuf.sv
// ---------------------------------------------------------------------------
// asc_rbuf
// Small result queue in front of the master port.
// ---------------------------------------------------------------------------
module asc_rbuf
    import asc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_result            i_data,
    input  logic               i_pop,
    output logic               o_valid,
    output t_result            o_data,
    output logic [RBUF_CW-1:0] o_count
);

    t_result              r_ent [RBUF_DEPTH];
    logic [RBUF_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [RBUF_CW-1:0]   r_count;
    logic                 w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_ent[r_rd_ptr];
    assign o_count = r_count;

    function automatic logic [RBUF_AW-1:0] ptr_inc(input logic [RBUF_AW-1:0] p);
        ptr_inc = (p == RBUF_AW'(RBUF_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: hdl/alignment_site_classifier_top.sv
// ---------------------------------------------------------------------------
// alignment_site_classifier_top
// Classifies alignment columns streamed one entry per beat and keeps totals.
// ---------------------------------------------------------------------------
//  channel   dir  signals                         payload
//  entries   in   i_s_tvalid/o_s_tready/i_s_tdata symbol; tuser = kind; tlast = column end
//  results   out  o_m_tvalid/i_m_tready/o_m_tdata six flags, six 24-bit totals
//
//  One entry beat per cycle sustained while the result queue has room,
//  set by the histogram RAM read-modify-write with a forward path.
//  A column's result passes the histogram stage register, then the result queue.
//  Synchronous active-low reset; no clearing pass, per-entry valid bits
//  reset the histogram at once and again at every column end.
//  A three-deep result queue absorbs master stalls; the slave side stalls
//  only when the queue plus a pending result could overflow.
// ---------------------------------------------------------------------------
module alignment_site_classifier_top
    import asc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side: entry beats
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [TDATA_IN_W-1:0]  i_s_tdata,   // [5:0] symbol, [7:6] zero
    input  logic [TUSER_IN_W-1:0]  i_s_tuser,   // [1:0] kind
    input  logic                   i_s_tlast,   // last_in_column
    // master side: one beat per column
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [TDATA_OUT_W-1:0] o_m_tdata    // [0] is_different, [1] informative_site,
                                                // [2] has_gap, [3] different_with_gaps,
                                                // [4] informative_with_gaps,
                                                // [5] no_letters, [29:6] total_columns,
                                                // [53:30] total_different,
                                                // [77:54] total_informative,
                                                // [101:78] total_different_gaps,
                                                // [125:102] total_informative_gaps,
                                                // [149:126] total_gapped, rest zero
);

    t_evt               w_evt;
    logic               w_acc;
    logic               w_push;
    t_result            w_result;
    t_result            w_out;
    logic [RBUF_CW-1:0] w_count;
    logic [RBUF_CW:0]   w_need;

    assign w_acc = i_s_tvalid && o_s_tready;

    // room for the result still in the histogram stage plus one more
    assign w_need     = {1'b0, w_count} + (RBUF_CW+1)'(w_evt.valid && w_evt.last);
    assign o_s_tready = (w_need < (RBUF_CW+1)'(RBUF_DEPTH));

    asc_hist u_hist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (w_acc),
        .i_symbol (i_s_tdata[SYM_W-1:0]),
        .i_kind   (t_kind'(i_s_tuser)),
        .i_last   (i_s_tlast),
        .o_evt    (w_evt)
    );

    asc_classify u_classify (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_evt    (w_evt),
        .o_push   (w_push),
        .o_result (w_result)
    );

    asc_rbuf u_rbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .i_pop   (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_data  (w_out),
        .o_count (w_count)
    );

    assign o_m_tdata = {(TDATA_OUT_W - RESULT_W)'(0), w_out};

endmodule

FILE: hdl/asc_checker.sv
// ---------------------------------------------------------------------------
// asc_checker
// Port-level checks on the classifier, bound to the top level.
// ---------------------------------------------------------------------------
`include "alignment_site_classifier_top_macros.svh"

module asc_checker
    import asc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [TDATA_OUT_W-1:0] o_m_tdata
);

    t_result w_res;
    logic    w_flags_ok;
    logic    w_order_ok;

    assign w_res = t_result'(o_m_tdata[RESULT_W-1:0]);

    // gap flag feeds the with-gaps flag; informative needs two letters
    assign w_flags_ok = (w_res.different_with_gaps == (w_res.is_different | w_res.has_gap))
                        && (!w_res.informative_site || w_res.is_different)
                        && (!w_res.no_letters || !w_res.is_different);

    assign w_order_ok = (w_res.total_columns != '0)
                        && (w_res.total_different <= w_res.total_columns)
                        && (w_res.total_informative <= w_res.total_different)
                        && (w_res.total_gapped <= w_res.total_different_gaps);

    // stalled result beat holds
    `ASC_ASSERT_NXT(a_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "held")

    // flags agree with each other
    `ASC_ASSERT_IMP(a_flags, o_m_tvalid, w_flags_ok, "inconsistent column flags")

    // totals stay in order: different within columns, informative within different, gapped within different-with-gaps
    `ASC_ASSERT_IMP(a_totals, o_m_tvalid, w_order_ok, "totals out of order")

    // nothing to send straight after reset
    `ASC_ASSERT_RST(a_rst_idle, !i_rst_n, !o_m_tvalid, "result valid after reset")

endmodule

bind alignment_site_classifier_top asc_checker u_asc_checker (.*);

FILE: verif/tb_alignment_site_classifier_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_alignment_site_classifier_top
// Streams alignment columns into the site classifier and checks the result
// beat of every column against a column-level model of the histogram, the
// tallies and the saturating totals. Both sides idle at random in phases.
// ---------------------------------------------------------------------------
module tb_alignment_site_classifier_top;
    import asc_pkg::*;

    localparam int MAX_SEQ     = 1023;     // per-column tally ceiling
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 20;       // idle wait after the last result, for strays
    localparam int EXP_DEPTH   = 64;       // outstanding column results

    // -----------------------------------------------------------------------
    // Column model and result store
    // -----------------------------------------------------------------------
    class column_classifier_model;
        int unsigned        letter_cnt[ALPHABET_SIZE];
        int unsigned        feature_cnt;
        int unsigned        gap_cnt;
        int unsigned        distinct_cnt;
        int unsigned        repeat_cnt;
        logic [TOTAL_W-1:0] totals[N_TOTALS];
        t_result            expected_columns[EXP_DEPTH];
        int unsigned        exp_head;
        int unsigned        exp_tail;
        int unsigned        failures;

        function new();
            foreach (totals[i]) totals[i] = '0;
            exp_head = 0;
            exp_tail = 0;
            failures = 0;
            clear_column();
        endfunction

        function void clear_column();
            foreach (letter_cnt[i]) letter_cnt[i] = 0;
            feature_cnt  = 0;
            gap_cnt      = 0;
            distinct_cnt = 0;
            repeat_cnt   = 0;
        endfunction

        function int unsigned sat_bump(int unsigned v);
            return (v < MAX_SEQ) ? v + 1 : v;
        endfunction

        function void bump_total(int slot, bit flag);
            if (flag && totals[slot] != '1) totals[slot] = totals[slot] + 1'b1;
        endfunction

        // one accepted entry beat
        function void note_entry(logic [SYM_W-1:0] sym, t_kind kind, logic last);
            int unsigned prev;
            t_result     r;
            bit          diff, inf, gap, diff2, inf2;
            case (kind)
                KIND_LETTER: begin
                    if (int'(sym) < ALPHABET_SIZE) begin
                        prev           = letter_cnt[sym];
                        letter_cnt[sym] = sat_bump(prev);
                        if (prev == 0) distinct_cnt++;
                        if (prev == 1) repeat_cnt++;
                        feature_cnt = sat_bump(feature_cnt);
                    end
                end
                KIND_FEATURE: feature_cnt = sat_bump(feature_cnt);
                KIND_GAP:     gap_cnt     = sat_bump(gap_cnt);
                default: ;
            endcase
            if (!last) return;

            diff  = distinct_cnt > 1;
            inf   = repeat_cnt > 1;
            gap   = gap_cnt > 0;
            diff2 = diff || gap;
            inf2  = inf || (gap_cnt > 1 && feature_cnt > 1);
            bump_total(TOT_COLUMNS, 1'b1);
            bump_total(TOT_DIFF, diff);
            bump_total(TOT_INF, inf);
            bump_total(TOT_DIFF_GAPS, diff2);
            bump_total(TOT_INF_GAPS, inf2);
            bump_total(TOT_GAPPED, gap);

            r.is_different           = diff;
            r.informative_site       = inf;
            r.has_gap                = gap;
            r.different_with_gaps    = diff2;
            r.informative_with_gaps  = inf2;
            r.no_letters             = (distinct_cnt == 0);
            r.total_columns          = totals[TOT_COLUMNS];
            r.total_different        = totals[TOT_DIFF];
            r.total_informative      = totals[TOT_INF];
            r.total_different_gaps   = totals[TOT_DIFF_GAPS];
            r.total_informative_gaps = totals[TOT_INF_GAPS];
            r.total_gapped           = totals[TOT_GAPPED];
            if (exp_tail - exp_head >= EXP_DEPTH) begin
                $error("too many column results outstanding");
                failures++;
            end else begin
                expected_columns[exp_tail % EXP_DEPTH] = r;
                exp_tail++;
            end
            clear_column();
        endfunction

        function void cmp(string name, longint unsigned expv, longint unsigned actv);
            if (expv != actv) begin
                $error("%s: expected %0d, got %0d", name, expv, actv);
                failures++;
            end
        endfunction

        // one accepted result beat
        function void check_beat(logic [TDATA_OUT_W-1:0] tdata);
            t_result want;
            t_result got;
            if (exp_tail == exp_head) begin
                $error("result beat with no column outstanding");
                failures++;
                return;
            end
            want = expected_columns[exp_head % EXP_DEPTH];
            exp_head++;
            got  = t_result'(tdata[RESULT_W-1:0]);
            cmp("is_different", want.is_different, got.is_different);
            cmp("informative_site", want.informative_site, got.informative_site);
            cmp("has_gap", want.has_gap, got.has_gap);
            cmp("different_with_gaps", want.different_with_gaps, got.different_with_gaps);
            cmp("informative_with_gaps", want.informative_with_gaps,
                got.informative_with_gaps);
            cmp("no_letters", want.no_letters, got.no_letters);
            cmp("total_columns", want.total_columns, got.total_columns);
            cmp("total_different", want.total_different, got.total_different);
            cmp("total_informative", want.total_informative, got.total_informative);
            cmp("total_different_gaps", want.total_different_gaps,
                got.total_different_gaps);
            cmp("total_informative_gaps", want.total_informative_gaps,
                got.total_informative_gaps);
            cmp("total_gapped", want.total_gapped, got.total_gapped);
            cmp("tdata padding", 0, tdata[TDATA_OUT_W-1:RESULT_W]);
        endfunction

        function int pending();
            return int'(exp_tail - exp_head);
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // DUT and stimulus signals, the stimulus known from time zero
    // -----------------------------------------------------------------------
    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [TDATA_IN_W-1:0]  i_s_tdata  = '0;   // [5:0] symbol, [7:6] zero
    logic [TUSER_IN_W-1:0]  i_s_tuser  = '0;   // [1:0] kind
    logic                   i_s_tlast  = 1'b0; // last_in_column
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] o_m_tdata;         // six flags then six totals

    column_classifier_model columns;
    int unsigned            send_idle_pct  = 0;
    int unsigned            recv_stall_pct = 0;
    int unsigned            entries_sent   = 0;
    int unsigned            cycle_count    = 0;

    alignment_site_classifier_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle on the falling edge
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor: sampled on the rising edge, pre-update values
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) columns.check_beat(o_m_tdata);
    end

    // -----------------------------------------------------------------------
    // Entry driver. Called on a falling edge, returns on the falling edge
    // after the beat was taken. tvalid gets one assignment per edge, so a
    // back-to-back beat keeps it high without a glitch.
    // -----------------------------------------------------------------------
    task automatic send_entry(logic [SYM_W-1:0] sym, t_kind kind, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= TDATA_IN_W'(sym);
        i_s_tuser  <= kind;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        columns.note_entry(sym, kind, last);
        entries_sent++;
        @(negedge i_clk);
    endtask

    // a run of identical entries that does not close the column
    task automatic send_run(logic [SYM_W-1:0] sym, t_kind kind, int count);
        repeat (count) send_entry(sym, kind, 1'b0);
    endtask

    // random column: mostly short, letters drawn from a narrow pool half
    // the time so that repeats and informative columns turn up often
    task automatic send_random_column();
        int unsigned      len;
        int unsigned      pick;
        logic [SYM_W-1:0] base;
        logic [SYM_W-1:0] sym;
        bit               narrow;
        t_kind            kind;
        len    = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        narrow = 1'($urandom_range(1));
        base   = SYM_W'($urandom_range(63));
        for (int n = 0; n < len; n++) begin
            pick = $urandom_range(99);
            if (pick < 60)      kind = KIND_LETTER;
            else if (pick < 75) kind = KIND_FEATURE;
            else if (pick < 90) kind = KIND_GAP;
            else                kind = KIND_OTHER;
            sym = narrow ? base + SYM_W'($urandom_range(3)) : SYM_W'($urandom_range(63));
            send_entry(sym, kind, n == len - 1);
        end
    endtask

    task automatic random_phase(int unsigned count);
        int unsigned stop_at;
        stop_at = entries_sent + count;
        while (entries_sent < stop_at) send_random_column();
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        columns = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // phase one: light sender gaps, heavy receiver stalls
        send_idle_pct  = 15;
        recv_stall_pct = 67;

        // single letter: constant column
        send_entry(6'd0, KIND_LETTER, 1'b1);
        // extreme codes, two distinct letters
        send_entry(6'd63, KIND_LETTER, 1'b0);
        send_entry(6'd0, KIND_LETTER, 1'b1);
        // two letters each twice: informative
        send_entry(6'd5, KIND_LETTER, 1'b0);
        send_entry(6'd9, KIND_LETTER, 1'b0);
        send_entry(6'd5, KIND_LETTER, 1'b0);
        send_entry(6'd9, KIND_LETTER, 1'b1);
        // all-gap column, no letters
        send_entry(6'd17, KIND_GAP, 1'b0);
        send_entry(6'd40, KIND_GAP, 1'b1);
        // two gaps and two non-letter features
        send_entry(6'd0, KIND_GAP, 1'b0);
        send_entry(6'd63, KIND_FEATURE, 1'b0);
        send_entry(6'd21, KIND_GAP, 1'b0);
        send_entry(6'd42, KIND_FEATURE, 1'b1);
        // letters count as features too
        send_entry(6'd3, KIND_GAP, 1'b0);
        send_entry(6'd7, KIND_LETTER, 1'b0);
        send_entry(6'd3, KIND_GAP, 1'b0);
        send_entry(6'd7, KIND_LETTER, 1'b1);
        // other/missing entries count for nothing
        send_entry(6'd63, KIND_OTHER, 1'b0);
        send_entry(6'd0, KIND_OTHER, 1'b1);
        // one letter, one feature, one gap: different only through the gap
        send_entry(6'd1, KIND_LETTER, 1'b0);
        send_entry(6'd33, KIND_FEATURE, 1'b0);
        send_entry(6'd12, KIND_GAP, 1'b1);

        random_phase(210);

        // phase two: the other way round
        send_idle_pct  = 67;
        recv_stall_pct = 15;
        random_phase(210);

        // phase three: no idling on either side
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // long columns: tallies run well past the two-count thresholds
        send_run(6'd42, KIND_LETTER, 30);
        send_entry(6'd3, KIND_LETTER, 1'b0);
        send_entry(6'd3, KIND_LETTER, 1'b1);
        send_run(6'd11, KIND_GAP, 30);
        send_entry(6'd9, KIND_FEATURE, 1'b1);

        random_phase(180);
        i_s_tvalid <= 1'b0;

        // drain: every column result, then a few spare cycles for strays
        while (columns.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (columns.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
